@@ hdl/pll_divider_search_unit_assert.svh @@
// ----------------------------------------------------------------------------
// PLL divider search unit assertion macros
// Shared property macros for the divider search checks.
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_UNIT_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// PLL divider search package
// Widths, constants and interface types shared by the divider search modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pds_pkg;

   // search range of the reference divider r and the multiplier v
   localparam int unsigned MAX_FACTOR = 63;
   localparam int unsigned FAC_W      = $clog2(MAX_FACTOR + 1);
   localparam logic [FAC_W-1:0] MAX_F = FAC_W'(MAX_FACTOR);

   localparam int unsigned REF_W     = 26;
   localparam int unsigned TGT_W     = 28;
   localparam int unsigned OUT_FAC_W = 6;
   localparam logic [REF_W-1:0] REF_RESET = 26'd32000000;

   // v * ref never exceeds this width
   localparam int unsigned PROD_W = REF_W + FAC_W;

   // radix-16 restoring divider: four quotient bits per cycle
   localparam int unsigned RADIX_BITS = 4;
   localparam int unsigned DIV_STEPS  = (PROD_W + RADIX_BITS - 1) / RADIX_BITS;
   localparam int unsigned DIV_W      = DIV_STEPS * RADIX_BITS;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam int unsigned REQ_DATA_W = ((TGT_W + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W = ((2 * OUT_FAC_W + TGT_W + 7) / 8) * 8;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [FAC_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [FAC_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic init;       // new target, clear best
      logic load_full;  // latch MAX_FACTOR * ref / r
      logic load_base;  // latch ref / r
      logic step;       // score current pair, move to v - 1
   } walk_ctl_type;

   typedef struct packed {
      logic             found;
      logic [FAC_W-1:0] r;
      logic [FAC_W-1:0] v;
      logic [TGT_W-1:0] err;
   } best_type;

endpackage

@@ hdl/pds_divider.sv @@
// ----------------------------------------------------------------------------
// PLL divider search: iterative divider
// Restoring divider of a wide dividend by a small divisor, four bits a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_divider
   import pds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]      quot_ff, quot_in;
   logic [FAC_W-1:0]      rem_ff, rem_in;
   logic [FAC_W-1:0]      divisor_ff, divisor_in;

   logic                  last;
   logic [RADIX_BITS-1:0] qbits;
   logic [FAC_W-1:0]      rem_step;
   logic [FAC_W:0]        part;

   assign last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // four dependent compare/subtract steps on a narrow remainder
   always_comb begin
      rem_step = rem_ff;
      qbits    = '0;
      part     = '0;
      for (int i = 0; i < RADIX_BITS; i++) begin
         part = {rem_step, quot_ff[DIV_W-1-i]};
         if (part >= {1'b0, divisor_ff}) begin
            part                   = part - {1'b0, divisor_ff};
            qbits[RADIX_BITS-1-i] = 1'b1;
         end
         rem_step = part[FAC_W-1:0];
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quot_in    = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff + 1'b1;
         quot_in = {quot_ff[DIV_W-RADIX_BITS-1:0], qbits};
         rem_in  = rem_step;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

@@ hdl/pds_walk.sv @@
// ----------------------------------------------------------------------------
// PLL divider search: multiplier walk
// Steps floor(v * ref / r) down in v by quotient/remainder updates and keeps
// the best pair seen so far.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_walk
   import pds_pkg::*;
(
   input  logic             clock,
   input  walk_ctl_type     ctl,
   input  logic [TGT_W-1:0] target,
   input  logic [FAC_W-1:0] r,
   input  logic [FAC_W-1:0] v,
   input  div_rsp_type      div_rsp,
   output best_type         best
);

   logic [TGT_W-1:0]  target_ff, target_in;
   logic [PROD_W-1:0] q_ff, q_in;
   logic [FAC_W-1:0]  rem_ff, rem_in;
   logic [REF_W-1:0]  qr_ff, qr_in;
   logic [FAC_W-1:0]  rr_ff, rr_in;
   best_type          best_ff, best_in;

   logic [PROD_W-1:0] tgt_ext;
   logic [PROD_W-1:0] err;
   logic              take;
   logic [FAC_W:0]    rem_diff;
   logic              borrow;

   assign tgt_ext = PROD_W'(target_ff);
   assign err     = (tgt_ext >= q_ff) ? (tgt_ext - q_ff) : (q_ff - tgt_ext);
   // ties go to the later pair
   assign take    = (err <= PROD_W'(best_ff.err));

   // (v-1)*ref = (q - qr)*r + (rem - rr); fix up when the remainder goes negative
   assign rem_diff = {1'b0, rem_ff} - {1'b0, rr_ff};
   assign borrow   = rem_diff[FAC_W];

   always_comb begin
      target_in = target_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      qr_in     = qr_ff;
      rr_in     = rr_ff;
      best_in   = best_ff;
      if (ctl.init) begin
         target_in     = target;
         best_in.found = 1'b0;
         best_in.r     = '0;
         best_in.v     = '0;
         best_in.err   = target;
      end
      if (ctl.load_full) begin
         q_in   = div_rsp.quot[PROD_W-1:0];
         rem_in = div_rsp.rem;
      end
      if (ctl.load_base) begin
         qr_in = div_rsp.quot[REF_W-1:0];
         rr_in = div_rsp.rem;
      end
      if (ctl.step) begin
         if (take) begin
            best_in.found = 1'b1;
            best_in.r     = r;
            best_in.v     = v;
            best_in.err   = err[TGT_W-1:0];
         end
         q_in = q_ff - PROD_W'(qr_ff) - PROD_W'(borrow);
         if (borrow) begin
            rem_in = rem_diff[FAC_W-1:0] + r;
         end else begin
            rem_in = rem_diff[FAC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      qr_ff     <= qr_in;
      rr_ff     <= rr_in;
      best_ff   <= best_in;
   end

   assign best = best_ff;

endmodule

@@ hdl/pll_divider_search_unit.sv @@
// ----------------------------------------------------------------------------
// PLL divider search unit
// Finds the reference divider r and multiplier v that bring floor(v*ref/r)
// closest to a target frequency.
// ----------------------------------------------------------------------------
// For each target word, at the default range of 1..63, the shared radix-16
// divider runs twice for every r (MAX_FACTOR*ref/r and ref/r), then the walk
// unit scores one multiplier per cycle from v = 63 down to 1. req_tready is
// low for the whole search; a finished result waits in the output register
// and the next target is taken while it waits. Write the reference frequency
// only when the unit is idle.
`timescale 1ns / 1ps
`include "pll_divider_search_unit_assert.svh"

module pll_divider_search_unit
   import pds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // target word
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [27:0] target_freq
   // result word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] ref_divider, [11:6] vco_multiplier,
                                              // [39:12] freq_error
   output logic                  rsp_tuser,   // [0] found
   // reference frequency register
   input  logic                  csr_wr_en,
   input  logic [REF_W-1:0]      csr_wr_data
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DIV_FULL = 5'b00010,
      S_DIV_BASE = 5'b00100,
      S_WALK     = 5'b01000,
      S_FINISH   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [FAC_W-1:0]       r_ff, r_in;
   logic [FAC_W-1:0]       v_ff, v_in;
   logic [REF_W-1:0]       reference_ff, reference_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   div_req_type            div_req;
   div_rsp_type            div_rsp;
   walk_ctl_type           walk_ctl;
   best_type               best;

   logic                   req_fire;
   logic                   rsp_load;
   logic [PROD_W-1:0]      full_dividend;
   logic [TGT_W-1:0]       rsp_err;

   assign req_tready    = (state_ff == S_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign full_dividend = PROD_W'(reference_ff) * PROD_W'(MAX_F);
   assign reference_in  = csr_wr_en ? csr_wr_data : reference_ff;

   always_comb begin
      state_in         = state_ff;
      r_in             = r_ff;
      v_in             = v_ff;
      rsp_load         = 1'b0;
      walk_ctl         = '0;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(full_dividend);
      div_req.divisor  = r_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               walk_ctl.init   = 1'b1;
               div_req.start   = 1'b1;
               div_req.divisor = MAX_F;
               r_in            = MAX_F;
               state_in        = S_DIV_FULL;
            end
         end
         S_DIV_FULL: begin
            if (div_rsp.done) begin
               walk_ctl.load_full = 1'b1;
               div_req.start      = 1'b1;
               div_req.dividend   = DIV_W'(reference_ff);
               state_in           = S_DIV_BASE;
            end
         end
         S_DIV_BASE: begin
            if (div_rsp.done) begin
               walk_ctl.load_base = 1'b1;
               v_in               = MAX_F;
               state_in           = S_WALK;
            end
         end
         S_WALK: begin
            walk_ctl.step = 1'b1;
            v_in          = v_ff - 1'b1;
            if (v_ff == FAC_W'(1)) begin
               if (r_ff == FAC_W'(1)) begin
                  state_in = S_FINISH;
               end else begin
                  r_in            = r_ff - 1'b1;
                  div_req.start   = 1'b1;
                  div_req.divisor = r_ff - 1'b1;
                  state_in        = S_DIV_FULL;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   pds_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   pds_walk u_walk (
      .clock   (clock),
      .ctl     (walk_ctl),
      .target  (req_tdata[TGT_W-1:0]),
      .r       (r_ff),
      .v       (v_ff),
      .div_rsp (div_rsp),
      .best    (best)
   );

   // result register; the fields are zero when no pair qualified
   assign rsp_err = best.found ? best.err : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = best.found;
         rsp_data_in  = RSP_DATA_W'({rsp_err,
                                     OUT_FAC_W'(best.found ? best.v : '0),
                                     OUT_FAC_W'(best.found ? best.r : '0)});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         reference_ff <= REF_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         reference_ff <= reference_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `PDS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready,
      "target accepted but unit still ready")
   `PDS_ASSERT_IMPL(a_divisor_nonzero, clock, reset,
      (state_ff == S_DIV_FULL) || (state_ff == S_DIV_BASE) || (state_ff == S_WALK),
      r_ff != '0, "reference divider reached zero during search")
   `PDS_ASSERT_IMPL(a_done_in_division, clock, reset, div_rsp.done,
      (state_ff == S_DIV_FULL) || (state_ff == S_DIV_BASE),
      "divider finished outside a division state")
   `PDS_ASSERT_IMPL(a_no_fit_is_zero, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata == '0, "result without a fit carries nonzero fields")

endmodule
